/* src/eld_pkg.sv */
package eld_pkg;

   // Result kinds, as seen on the result channel.
   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_EMPTY_OK = 3'd1,
      KIND_BAD_SUM  = 3'd2,
      KIND_TOO_BIG  = 3'd3,
      KIND_STRAY    = 3'd4,
      KIND_TIMEOUT  = 3'd5
   } kind_type;

   // Parser phase of the front end.
   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_SIZE  = 2'd1,
      PH_DATA  = 2'd2,
      PH_CHECK = 2'd3
   } phase_type;

   // Sequencer state of the back end.
   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_READ = 2'd1,
      BK_LOAD = 2'd2
   } back_state_type;

   // Register addresses (word index on the CSR port).
   typedef enum logic [1:0] {
      REG_START_BYTE  = 2'd0,
      REG_ESCAPE_BYTE = 2'd1,
      REG_ESCAPE_MASK = 2'd2,
      REG_UNUSED      = 2'd3
   } reg_index_type;

   localparam logic [7:0] START_BYTE_RESET  = 8'h7E;
   localparam logic [7:0] ESCAPE_BYTE_RESET = 8'h7D;
   localparam logic [7:0] ESCAPE_MASK_RESET = 8'h20;

   // Depth of the command queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 4;

   // Framing configuration handed to the front end.
   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] escape_byte;
      logic [7:0] escape_mask;
   } cfg_type;

   // One command for the back end. For a good frame with payload the kind
   // is KIND_DATA and data holds the frame length; otherwise data is the
   // byte reported with the status.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } cmd_type;

endpackage

/* src/eld_if.sv */
// Input channel: one received byte or one idle-timeout tick per item.
interface eld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       idle_timeout;

   modport source (output valid, output rx_byte, output idle_timeout, input ready);
   modport sink (input valid, input rx_byte, input idle_timeout, output ready);
endinterface

// Result channel: payload bytes and status results.
interface eld_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] payload_byte;
   logic       last;

   modport source (output valid, output kind, output payload_byte, output last, input ready);
   modport sink (input valid, input kind, input payload_byte, input last, output ready);
endinterface

/* src/eld_ram.sv */
module eld_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/eld_front.sv */
module eld_front #(
   parameter int unsigned STORE_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  eld_pkg::cfg_type               cfg,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [7:0]                     in_byte,
   input  logic                           in_tick,
   input  logic                           q_full,
   output logic                           push,
   output eld_pkg::cmd_type               push_cmd,
   input  logic                           replay_done,
   output logic                           wr_en,
   output logic [$clog2(STORE_DEPTH)-1:0] wr_addr,
   output logic [7:0]                     wr_data
);
   import eld_pkg::*;

   localparam int unsigned LEN_W = $clog2(STORE_DEPTH);

   phase_type        phase_ff, phase_in;
   logic             esc_ff, esc_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [7:0]       xor_ff, xor_in;
   logic             owed_ff, owed_in;
   logic             accept;
   logic             is_esc;
   logic [7:0]       decoded;
   logic [LEN_W:0]   fill_next;

   // A payload byte waits while the store still holds a frame being replayed.
   assign in_ready  = !q_full && !((phase_ff == PH_DATA) && owed_ff);
   assign accept    = in_valid && in_ready;
   assign is_esc    = (in_byte == cfg.escape_byte);
   assign decoded   = esc_ff ? (in_byte ^ cfg.escape_mask) : in_byte;
   assign fill_next = {1'b0, fill_ff} + 1'b1;
   assign wr_addr   = fill_ff;
   assign wr_data   = decoded;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         esc_ff   <= 1'b0;
         len_ff   <= '0;
         fill_ff  <= '0;
         xor_ff   <= '0;
         owed_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         xor_ff   <= xor_in;
         owed_ff  <= owed_in;
      end
   end

   // Parser: classify each accepted item and queue any result it causes.
   always_comb begin
      phase_in = phase_ff;
      esc_in   = esc_ff;
      len_in   = len_ff;
      fill_in  = fill_ff;
      xor_in   = xor_ff;
      owed_in  = owed_ff && !replay_done;
      push     = 1'b0;
      push_cmd = '{kind: KIND_DATA, data: 8'h00};
      wr_en    = 1'b0;
      if (accept) begin
         if (in_tick) begin
            if (phase_ff != PH_HUNT) begin
               phase_in = PH_HUNT;
               push     = 1'b1;
               push_cmd = '{kind: KIND_TIMEOUT, data: 8'h00};
            end
         end else if (phase_ff == PH_HUNT) begin
            if (in_byte == cfg.start_byte) begin
               fill_in  = '0;
               phase_in = PH_SIZE;
            end else begin
               push     = 1'b1;
               push_cmd = '{kind: KIND_STRAY, data: in_byte};
            end
         end else if (is_esc) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            unique case (phase_ff)
               PH_HUNT: begin
               end
               PH_SIZE: begin
                  if ({1'b0, decoded} > 9'(STORE_DEPTH - 1)) begin
                     phase_in = PH_HUNT;
                     push     = 1'b1;
                     push_cmd = '{kind: KIND_TOO_BIG, data: decoded};
                  end else begin
                     len_in   = decoded[LEN_W-1:0];
                     xor_in   = decoded;
                     fill_in  = '0;
                     phase_in = (decoded == 8'h00) ? PH_CHECK : PH_DATA;
                  end
               end
               PH_DATA: begin
                  wr_en   = 1'b1;
                  xor_in  = xor_ff ^ decoded;
                  fill_in = fill_next[LEN_W-1:0];
                  if (fill_next >= {1'b0, len_ff}) begin
                     phase_in = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  phase_in = PH_HUNT;
                  push     = 1'b1;
                  if (decoded != xor_ff) begin
                     push_cmd = '{kind: KIND_BAD_SUM, data: decoded};
                  end else if (len_ff == '0) begin
                     push_cmd = '{kind: KIND_EMPTY_OK, data: 8'h00};
                  end else begin
                     push_cmd = '{kind: KIND_DATA, data: 8'(len_ff)};
                     owed_in  = 1'b1;
                  end
               end
            endcase
         end
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("command pushed into a full queue");

   a_no_write_during_replay: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !owed_ff)
      else $error("payload store written while a replay is pending");
`endif
endmodule

/* src/eld_queue.sv */
module eld_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  eld_pkg::cmd_type push_cmd,
   input  logic             pop,
   output eld_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import eld_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

/* src/eld_back.sv */
module eld_back #(
   parameter int unsigned STORE_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  eld_pkg::cmd_type               head,
   input  logic                           q_empty,
   output logic                           pop,
   output logic                           rd_en,
   output logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
   input  logic [7:0]                     rd_data,
   output logic                           replay_done,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [2:0]                     out_kind,
   output logic [7:0]                     out_byte,
   output logic                           out_last
);
   import eld_pkg::*;

   localparam int unsigned LEN_W = $clog2(STORE_DEPTH);

   back_state_type   state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   kind_type         kind_ff, kind_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             out_free;
   logic [LEN_W:0]   idx_next;
   logic             at_last;

   assign out_free  = !valid_ff || out_ready;
   assign idx_next  = {1'b0, idx_ff} + 1'b1;
   assign at_last   = (idx_next == {1'b0, len_ff});
   assign rd_addr   = idx_ff;
   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
         len_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   // Sequencer: status commands pass straight out, good frames replay from the store.
   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      valid_in    = valid_ff && !out_ready;
      kind_in     = kind_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      pop         = 1'b0;
      rd_en       = 1'b0;
      replay_done = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && out_free) begin
               pop = 1'b1;
               if (head.kind == KIND_DATA) begin
                  len_in   = head.data[LEN_W-1:0];
                  idx_in   = '0;
                  state_in = BK_READ;
               end else begin
                  valid_in = 1'b1;
                  kind_in  = head.kind;
                  byte_in  = head.data;
                  last_in  = 1'b1;
               end
            end
         end
         BK_READ: begin
            rd_en    = 1'b1;
            state_in = BK_LOAD;
         end
         BK_LOAD: begin
            if (out_free) begin
               valid_in = 1'b1;
               kind_in  = KIND_DATA;
               byte_in  = rd_data;
               last_in  = at_last;
               if (at_last) begin
                  replay_done = 1'b1;
                  state_in    = BK_IDLE;
               end else begin
                  idx_in   = idx_next[LEN_W-1:0];
                  state_in = BK_READ;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_replay_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_LOAD) |-> ({1'b0, idx_ff} < {1'b0, len_ff}))
      else $error("replay index beyond frame length");
`endif
endmodule

/* src/escaped_length_frame_deframer_unit.sv */
// Escaped, length-prefixed frame deframer with an XOR check byte.
// Input channel req_chan carries one received byte, or one idle-timeout tick,
// per item. The front end hunts for the start byte, removes escapes, checks
// the size, stores the payload and compares the check byte. Result channel
// rsp_chan delivers a good frame as a burst of payload items, last set on
// the final byte; an empty frame or an error gives one status item, last set.
// A status item is written into the command queue and then into the output
// register. A good frame is queued on its check byte; the back end then reads
// each payload byte from the store, which has a registered read port, and
// loads it into the output register before it reads the next one.
// The front end takes one item per cycle while the queue has room. A payload
// byte of the next frame is held off while the previous frame is still being
// replayed, since both share the store. A four-entry command queue separates
// the two halves, so a stalled receiver only backs up the input once it fills.
// Reset (synchronous) empties the queue and output register, returns to
// hunting and restores the start byte 0x7E, escape byte 0x7D and mask 0x20.
// The CSR port holds these three registers at byte addresses 0, 4 and 8.
module escaped_length_frame_deframer_unit #(
   parameter int unsigned STORE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   eld_req_if.sink     req_chan,
   eld_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import eld_pkg::*;

   localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

   cfg_type            cfg_ff, cfg_in;
   reg_index_type      reg_sel;
   logic               csr_write;
   logic               q_full, q_empty, push, pop;
   cmd_type            push_cmd, head;
   logic               replay_done;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [7:0]         wr_data, rd_data;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_START_BYTE:  cfg_in.start_byte  = csr_pwdata[7:0];
            REG_ESCAPE_BYTE: cfg_in.escape_byte = csr_pwdata[7:0];
            REG_ESCAPE_MASK: cfg_in.escape_mask = csr_pwdata[7:0];
            REG_UNUSED: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_START_BYTE:  csr_prdata = {24'h0, cfg_ff.start_byte};
         REG_ESCAPE_BYTE: csr_prdata = {24'h0, cfg_ff.escape_byte};
         REG_ESCAPE_MASK: csr_prdata = {24'h0, cfg_ff.escape_mask};
         REG_UNUSED:      csr_prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{start_byte: START_BYTE_RESET, escape_byte: ESCAPE_BYTE_RESET,
                     escape_mask: ESCAPE_MASK_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: parser and store writer.
   eld_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_byte     (req_chan.rx_byte),
      .in_tick     (req_chan.idle_timeout),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd),
      .replay_done (replay_done),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   // Command queue between the halves.
   eld_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Payload store.
   eld_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Back end: result sequencer and output register.
   eld_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_empty     (q_empty),
      .pop         (pop),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .replay_done (replay_done),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_kind    (rsp_chan.kind),
      .out_byte    (rsp_chan.payload_byte),
      .out_last    (rsp_chan.last)
   );
endmodule

/* tb/escaped_length_frame_deframer_unit_tb.sv */
module escaped_length_frame_deframer_unit_tb;
   import eld_pkg::*;

   localparam int unsigned STORE_DEPTH    = 64;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 32;

   // One decoded output item as the result channel should deliver it.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic       last;
   } deframed_item_type;

   // One row of the directed stimulus; has_result marks a typed-in result.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       idle_timeout;
      logic       has_result;
      kind_type   kind;
      logic [7:0] payload_byte;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'h0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   eld_req_if req_chan ();
   eld_rsp_if rsp_chan ();

   escaped_length_frame_deframer_unit #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Mirror of the framing registers.
   logic [7:0] cfg_start  = START_BYTE_RESET;
   logic [7:0] cfg_escape = ESCAPE_BYTE_RESET;
   logic [7:0] cfg_mask   = ESCAPE_MASK_RESET;

   // Mirror of the parser state.
   phase_type   frame_phase = PH_HUNT;
   logic        escape_armed = 1'b0;
   int unsigned frame_size = 0;
   int unsigned fill_count = 0;
   logic [7:0]  check_xor = 8'h00;
   logic [7:0]  payload_copy [STORE_DEPTH];

   deframed_item_type expected_deframed [$];

   // Typed-in result that travels with the item on the input channel.
   logic       note_fixed = 1'b0;
   kind_type   note_kind = KIND_DATA;
   logic [7:0] note_byte = 8'h00;

   int unsigned sent_items = 0;
   int unsigned items_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned frames_replayed = 0;
   int unsigned settings_applied = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned req_gap_pct = 11;
   int unsigned rsp_stall_pct = 49;

   stim_row_type directed_rows [27] = '{
      '{8'hFF, 1'b1, 1'b0, KIND_DATA,     8'h00},
      '{8'h00, 1'b0, 1'b1, KIND_STRAY,    8'h00},
      '{8'hFF, 1'b0, 1'b1, KIND_STRAY,    8'hFF},
      '{8'h7D, 1'b0, 1'b1, KIND_STRAY,    8'h7D},
      '{8'h7E, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h40, 1'b0, 1'b1, KIND_TOO_BIG,  8'h40},
      '{8'h7E, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h7D, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'hDF, 1'b0, 1'b1, KIND_TOO_BIG,  8'hFF},
      '{8'h7E, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h00, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h00, 1'b0, 1'b1, KIND_EMPTY_OK, 8'h00},
      '{8'h7E, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h03, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h7E, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h7D, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h5D, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'hFF, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'hFF, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h7E, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h05, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h7D, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h00, 1'b1, 1'b1, KIND_TIMEOUT,  8'h00},
      '{8'h7E, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h21, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'h00, 1'b0, 1'b0, KIND_DATA,     8'h00},
      '{8'hAA, 1'b0, 1'b1, KIND_BAD_SUM,  8'hAA}
   };

   always #2 clock = ~clock;

   // Expected behavior of the deframer for one accepted input item.
   task automatic deframe_byte(input logic [7:0] raw, input logic tick);
      logic [7:0] b;
      logic       taken;
      b = raw;
      taken = 1'b1;
      // Escapes are removed in every phase except the hunt for a start byte.
      if (!tick && frame_phase != PH_HUNT) begin
         if (b == cfg_escape) begin
            escape_armed = 1'b1;
            taken = 1'b0;
         end else if (escape_armed) begin
            b = b ^ cfg_mask;
            escape_armed = 1'b0;
         end
      end
      if (tick) begin
         if (frame_phase != PH_HUNT) begin
            frame_phase = PH_HUNT;
            expected_deframed.push_back({KIND_TIMEOUT, 8'h00, 1'b1});
         end
      end else if (taken) begin
         case (frame_phase)
            PH_HUNT: begin
               if (b == cfg_start) begin
                  fill_count = 0;
                  frame_phase = PH_SIZE;
               end else begin
                  expected_deframed.push_back({KIND_STRAY, b, 1'b1});
               end
            end
            PH_SIZE: begin
               if (b > STORE_DEPTH - 1) begin
                  frame_phase = PH_HUNT;
                  expected_deframed.push_back({KIND_TOO_BIG, b, 1'b1});
               end else begin
                  frame_size = 32'(b);
                  check_xor = b;
                  fill_count = 0;
                  frame_phase = (b == 8'h00) ? PH_CHECK : PH_DATA;
               end
            end
            PH_DATA: begin
               if (fill_count < STORE_DEPTH) payload_copy[fill_count] = b;
               check_xor = check_xor ^ b;
               fill_count++;
               if (fill_count >= frame_size) frame_phase = PH_CHECK;
            end
            default: begin
               frame_phase = PH_HUNT;
               if (b != check_xor) begin
                  expected_deframed.push_back({KIND_BAD_SUM, b, 1'b1});
               end else if (frame_size == 0) begin
                  expected_deframed.push_back({KIND_EMPTY_OK, 8'h00, 1'b1});
               end else begin
                  for (int i = 0; i < frame_size; i++) begin
                     expected_deframed.push_back({KIND_DATA, payload_copy[i],
                                                  1'(i + 1 == frame_size)});
                  end
               end
            end
         endcase
      end
   endtask

   // Both channels are observed here, input first, so that ordering is fixed.
   always @(posedge clock) begin : watch_channels
      int unsigned       depth_before;
      deframed_item_type want;
      if (!reset && req_chan.valid && req_chan.ready) begin
         items_accepted++;
         depth_before = expected_deframed.size();
         deframe_byte(req_chan.rx_byte, req_chan.idle_timeout);
         // A directed row with a typed-in status replaces the prediction.
         if (note_fixed) begin
            while (expected_deframed.size() > depth_before) begin
               void'(expected_deframed.pop_back());
            end
            expected_deframed.push_back({note_kind, note_byte, 1'b1});
         end
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_checked++;
         if (expected_deframed.size() == 0) begin
            $error("unexpected item: kind %0d payload_byte 0x%02h last %0b",
                   rsp_chan.kind, rsp_chan.payload_byte, rsp_chan.last);
            error_count++;
         end else begin
            want = expected_deframed.pop_front();
            if (want.kind == KIND_DATA && want.last) frames_replayed++;
            if (rsp_chan.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_chan.kind);
               error_count++;
            end
            if (rsp_chan.payload_byte !== want.payload_byte) begin
               $error("payload_byte: expected 0x%02h, actual 0x%02h",
                      want.payload_byte, rsp_chan.payload_byte);
               error_count++;
            end
            if (rsp_chan.last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_chan.last);
               error_count++;
            end
         end
      end
   end

   // The receiver stalls at random according to the current pattern.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Ends the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offers one item after a random gap and returns at the edge that takes it.
   task automatic send_item(input logic [7:0] rx, input logic tick, input logic fixed,
                            input kind_type kind, input logic [7:0] pbyte);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= rx;
      req_chan.idle_timeout <= tick;
      note_fixed <= fixed;
      note_kind <= kind;
      note_byte <= pbyte;
      sent_items++;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_plain(input logic [7:0] value);
      send_item(value, 1'b0, 1'b0, KIND_DATA, 8'h00);
   endtask

   // Sends a frame byte, escaping it when needed and now and then by choice.
   task automatic send_coded(input logic [7:0] value);
      if (value == cfg_escape ||
          ((value ^ cfg_mask) != cfg_escape && $urandom_range(0, 7) == 0)) begin
         send_plain(cfg_escape);
         send_plain(value ^ cfg_mask);
      end else begin
         send_plain(value);
      end
   endtask

   // A complete frame; mostly short, now and then full size or oversized.
   task automatic send_frame();
      logic [7:0]  size;
      logic [7:0]  data;
      logic [7:0]  check;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) size = 8'($urandom_range(0, 4));
      else if (pick < 85) size = 8'($urandom_range(5, 12));
      else if (pick < 89) size = 8'($urandom_range(13, STORE_DEPTH - 2));
      else if (pick < 92) size = 8'(STORE_DEPTH - 1);
      else size = 8'($urandom_range(STORE_DEPTH, 255));
      send_plain(cfg_start);
      send_coded(size);
      if (size < STORE_DEPTH) begin
         check = size;
         for (int n = 0; n < size; n++) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) data = cfg_start;
            else if (pick == 1) data = cfg_escape;
            else data = 8'($urandom);
            send_coded(data);
            check = check ^ data;
         end
         // Roughly one frame in eight carries a corrupted check byte.
         if ($urandom_range(0, 7) == 0) check = check ^ 8'($urandom_range(1, 255));
         send_coded(check);
      end
   endtask

   // A frame cut short by a timeout, sometimes with an escape still pending.
   task automatic send_cut_frame();
      logic [7:0] size;
      size = 8'($urandom_range(1, 8));
      send_plain(cfg_start);
      send_coded(size);
      repeat ($urandom_range(0, size - 1)) send_plain(8'($urandom));
      if ($urandom_range(0, 1) == 1) send_plain(cfg_escape);
      send_item(8'($urandom), 1'b1, 1'b0, KIND_DATA, 8'h00);
   endtask

   // Mostly good frames, with broken frames, stray bytes and ticks mixed in.
   task automatic send_random(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      stop_at = sent_items + count;
      while (sent_items < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) send_frame();
         else if (pick < 80) send_cut_frame();
         else if (pick < 88) repeat ($urandom_range(1, 3)) send_plain(8'($urandom));
         else if (pick < 94) send_item(8'($urandom), 1'b1, 1'b0, KIND_DATA, 8'h00);
         else send_plain(cfg_escape);
      end
   endtask

   // Waits until every expected item has arrived and the block has settled.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_deframed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup phase, access phase, then a quiet phase with select low.
   task automatic csr_write(input reg_index_type index, input logic [7:0] value);
      logic [23:0] junk;
      junk = 24'($urandom);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {junk, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_START_BYTE:  cfg_start = value;
         REG_ESCAPE_BYTE: cfg_escape = value;
         REG_ESCAPE_MASK: cfg_mask = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] start, input logic [7:0] escape,
                                input logic [7:0] mask);
      csr_write(REG_START_BYTE, start);
      csr_write(REG_ESCAPE_BYTE, escape);
      csr_write(REG_ESCAPE_MASK, mask);
      settings_applied++;
   endtask

   initial begin : stimulus
      logic [7:0] rand_start;
      logic [7:0] rand_escape;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = 8'h00;
      req_chan.idle_timeout = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed rows under the reset values of the registers.
      settings_applied++;
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].rx_byte, directed_rows[i].idle_timeout,
                   directed_rows[i].has_result, directed_rows[i].kind,
                   directed_rows[i].payload_byte);
      end
      drain_results();

      // Start byte and escape at opposite extremes, full mask.
      apply_setting(8'h00, 8'hFF, 8'hFF);
      send_random(50);
      drain_results();

      // Swap the idle pattern; escape byte zero.
      req_gap_pct = 49;
      rsp_stall_pct = 11;
      apply_setting(8'hFF, 8'h00, 8'h80);
      send_random(50);
      drain_results();

      // No idling from here on; random framing bytes with an empty mask.
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      rand_start = 8'($urandom);
      rand_escape = 8'($urandom);
      if (rand_escape == rand_start) rand_escape = ~rand_start;
      apply_setting(rand_start, rand_escape, 8'h00);
      send_random(25);
      drain_results();

      // The unused register must leave the framing alone.
      csr_write(REG_UNUSED, 8'($urandom));
      apply_setting(START_BYTE_RESET, ESCAPE_BYTE_RESET, ESCAPE_MASK_RESET);
      send_random(25);
      drain_results();

      $display("Sent %0d input items; checked %0d result items, %0d good frames replayed.",
               items_accepted, results_checked, frames_replayed);
      $display("Covered %0d register settings and three idle patterns.", settings_applied);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
